// ===== rtl/core/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Types and opcodes shared by the top-K sorted insert list.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int SCORE_W = 24;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SCORE_W-1:0] new_score;
    logic [TAG_W-1:0]   new_tag;
    logic [SLOT_W-1:0]  slot_index;
  } tks_req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] entry_score;
    logic [TAG_W-1:0]   entry_tag;
    logic [COUNT_W-1:0] occupied_count;
    logic               placed;
    logic [SLOT_W-1:0]  place_index;
  } tks_rsp_t;

  // what one cell offers to the collection tree
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [SLOT_W-1:0]  slot;
  } tks_hit_t;

endpackage

// ===== rtl/core/tks_cell.sv =====
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the sorted list: compares the request score against its own,
// takes the neighbor's entry or the new record on insert, reports hits.
// ----------------------------------------------------------------------------
module tks_cell
  import tks_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tks_req_t           req,
  input  logic               prev_gt,
  input  logic [SCORE_W-1:0] prev_score,
  input  logic [TAG_W-1:0]   prev_tag,
  output logic               gt,
  output logic [SCORE_W-1:0] score,
  output logic [TAG_W-1:0]   tag,
  output tks_hit_t           hit
);

  localparam logic [SLOT_W-1:0] SLOT_ID  = SLOT_W'(CELL_INDEX % 256);
  localparam bit                IN_RANGE = (CELL_INDEX < 256);

  logic boundary;
  logic read_match;

  assign gt         = req.new_score > score;
  assign boundary   = gt && !prev_gt;
  assign read_match = IN_RANGE && (req.slot_index == SLOT_ID);

  always_comb begin
    hit = '0;
    case (req.opcode)
      OP_INSERT: begin
        if (boundary) hit.slot = SLOT_ID;
      end
      OP_READ: begin
        if (read_match) begin
          hit.score = score;
          hit.tag   = tag;
        end
      end
      default: hit = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
      tag   <= '0;
    end else if (load) begin
      case (req.opcode)
        OP_INSERT: begin
          if (gt) begin
            score <= prev_gt ? prev_score : req.new_score;
            tag   <= prev_gt ? prev_tag : req.new_tag;
          end
        end
        OP_CLEAR: begin
          score <= '0;
          tag   <= '0;
        end
        default: begin
          score <= score;
          tag   <= tag;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tks_collect.sv =====
// ----------------------------------------------------------------------------
// tks_collect
// Two-level OR tree that gathers the single hit of the cell row: groups are
// reduced and registered, then the group results are combined.
// ----------------------------------------------------------------------------
module tks_collect
  import tks_pkg::*;
#(
  parameter int CELLS = 256
) (
  input  logic     clk,
  input  logic     load,
  input  tks_hit_t hits [CELLS],
  output tks_hit_t merged
);

  localparam int GROUP  = 32;
  localparam int NGROUP = (CELLS + GROUP - 1) / GROUP;

  tks_hit_t group_or  [NGROUP];
  tks_hit_t group_reg [NGROUP];

  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    always_comb begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CELLS) group_or[g] = group_or[g] | hits[g * GROUP + k];
      end
    end

    always_ff @(posedge clk) begin
      if (load) group_reg[g] <= group_or[g];
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NGROUP; g++) begin
      merged = merged | group_reg[g];
    end
  end

endmodule

// ===== rtl/core/top_k_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Descending top-K list of scored records with insert, read and clear.
// ----------------------------------------------------------------------------
// The list is a row of LIST_DEPTH cells, each holding one score and tag. An
// insert compares the new score against every cell at once and each cell
// either holds, takes its upper neighbor's entry or takes the new record, so
// one request of any kind is accepted per clock while rsp_ready does not stall
// it. The grouped OR tree that gathers the read data and landing slot from
// the cells registers its group results, then the output register takes the
// response. Reset clears the whole list in the same cycle; no clearing pass.
// ----------------------------------------------------------------------------
module top_k_sorted_insert
  import tks_pkg::*;
#(
  parameter int LIST_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tks_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tks_rsp_t rsp
);

  localparam int FILL_W = $clog2(LIST_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(LIST_DEPTH);

  logic               gt    [LIST_DEPTH];
  logic [SCORE_W-1:0] score [LIST_DEPTH];
  logic [TAG_W-1:0]   tag   [LIST_DEPTH];
  tks_hit_t           hits  [LIST_DEPTH];
  tks_hit_t           merged;

  logic              load;
  logic              advance;
  logic              placed_now;
  logic [FILL_W-1:0] filled;
  logic [FILL_W-1:0] filled_next;

  logic               s1_valid;
  logic               s1_placed;
  logic [COUNT_W-1:0] s1_count;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;
  assign load      = req_valid && req_ready;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tks_cell #(.CELL_INDEX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (load),
        .req        (req),
        .prev_gt    (1'b0),
        .prev_score ('0),
        .prev_tag   ('0),
        .gt         (gt[i]),
        .score      (score[i]),
        .tag        (tag[i]),
        .hit        (hits[i])
      );
    end else begin : g_body
      tks_cell #(.CELL_INDEX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (load),
        .req        (req),
        .prev_gt    (gt[i-1]),
        .prev_score (score[i-1]),
        .prev_tag   (tag[i-1]),
        .gt         (gt[i]),
        .score      (score[i]),
        .tag        (tag[i]),
        .hit        (hits[i])
      );
    end
  end

  tks_collect #(.CELLS(LIST_DEPTH)) u_collect (
    .clk    (clk),
    .load   (load),
    .hits   (hits),
    .merged (merged)
  );

  // list sorted, so the last cell losing means some cell lost
  assign placed_now = (req.opcode == OP_INSERT) && gt[LIST_DEPTH-1];

  always_comb begin
    filled_next = filled;
    case (req.opcode)
      OP_INSERT: begin
        if (placed_now && filled < FULL) filled_next = filled + 1'b1;
      end
      OP_CLEAR: filled_next = '0;
      default:  filled_next = filled;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) filled <= filled_next;
      if (load) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance) rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_placed <= placed_now;
      s1_count  <= COUNT_W'(filled_next);
    end
    if (advance && s1_valid) begin
      rsp.entry_score    <= merged.score;
      rsp.entry_tag      <= merged.tag;
      rsp.occupied_count <= s1_count;
      rsp.placed         <= s1_placed;
      rsp.place_index    <= merged.slot;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the top-K sorted insert list.
// Requests go in through the valid/ready request port and are predicted on
// acceptance by an in-bench copy of the list; every response is compared
// field by field with the oldest prediction. Directed corner cases and
// random traffic under three idle profiles are run, with a full-list fill
// and a back-pressure test before the last profile's random traffic.
// ----------------------------------------------------------------------------
module tb;
  import tks_pkg::*;

  localparam int          LIST_DEPTH = 256;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          MAX_SHOWN  = 10;
  localparam longint      RUN_LIMIT  = 5_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  tks_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  tks_rsp_t rsp;

  top_k_sorted_insert #(.LIST_DEPTH(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // shadow copy of the list
  logic [SCORE_W-1:0] shadow_scores [LIST_DEPTH];
  logic [TAG_W-1:0]   shadow_tags   [LIST_DEPTH];
  int unsigned        shadow_filled;

  tks_rsp_t    expected_rsps [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned op_counts [4] = '{default: 0};
  int unsigned placed_count = 0;
  int unsigned peak_filled = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      shadow_scores[i] = '0;
      shadow_tags[i]   = '0;
    end
    shadow_filled = 0;
  endfunction

  function automatic tks_rsp_t apply_request(tks_req_t r);
    tks_rsp_t o;
    int       pos;
    o   = '0;
    pos = -1;
    case (r.opcode)
      OP_INSERT: begin
        for (int i = 0; i < LIST_DEPTH; i++)
          if (pos < 0 && r.new_score > shadow_scores[i]) pos = i;
        if (pos >= 0) begin
          for (int j = LIST_DEPTH - 1; j > pos; j--) begin
            shadow_scores[j] = shadow_scores[j-1];
            shadow_tags[j]   = shadow_tags[j-1];
          end
          shadow_scores[pos] = r.new_score;
          shadow_tags[pos]   = r.new_tag;
          if (shadow_filled < LIST_DEPTH) shadow_filled++;
          o.placed      = 1'b1;
          o.place_index = pos[SLOT_W-1:0];
          placed_count++;
        end
      end
      OP_READ: begin
        if (r.slot_index < LIST_DEPTH) begin
          o.entry_score = shadow_scores[r.slot_index];
          o.entry_tag   = shadow_tags[r.slot_index];
        end
      end
      OP_CLEAR: clear_shadow();
      default: ;
    endcase
    o.occupied_count = shadow_filled[COUNT_W-1:0];
    if (shadow_filled > peak_filled) peak_filled = shadow_filled;
    op_counts[r.opcode]++;
    return o;
  endfunction

  function automatic tks_req_t make_req(logic [1:0] op, logic [SCORE_W-1:0] score,
                                        logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] idx);
    tks_req_t r;
    r.opcode     = op;
    r.new_score  = score;
    r.new_tag    = tag;
    r.slot_index = idx;
    return r;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5)  return '0;
    if (roll < 30) return SCORE_W'($urandom_range(1, 8));
    if (roll < 35) return '1;
    if (roll < 50) return SCORE_W'($urandom_range(24'hFFFFFF, 24'hFFFF00));
    return SCORE_W'($urandom);
  endfunction

  task automatic send_request(input tks_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_rsps.push_back(apply_request(r));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      rsp_ready <= 1'b0;
      recv_hold--;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch in %s of response %0d: expected %0h, got %0h",
                 field, results_seen, want, got);
    end
  endfunction

  // response checker
  always @(posedge clk) begin
    tks_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected response %0d: %p", results_seen, rsp);
      end else begin
        want = expected_rsps.pop_front();
        check_field("entry_score",    32'(want.entry_score),    32'(rsp.entry_score));
        check_field("entry_tag",      32'(want.entry_tag),      32'(rsp.entry_tag));
        check_field("occupied_count", 32'(want.occupied_count), 32'(rsp.occupied_count));
        check_field("placed",         32'(want.placed),         32'(rsp.placed));
        check_field("place_index",    32'(want.place_index),    32'(rsp.place_index));
      end
      results_seen++;
    end
  end

  task automatic test_directed();
    send_request(make_req(OP_READ,   '0,         '0,       8'd0));
    send_request(make_req(OP_READ,   '0,         '0,       8'd255));
    send_request(make_req(OP_INSERT, '0,         16'hFFFF, 8'hFF));
    send_request(make_req(OP_INSERT, 24'hFFFFFF, 16'hAAAA, 8'h00));
    send_request(make_req(OP_INSERT, 24'hFFFFFF, 16'h5555, 8'hFF));
    send_request(make_req(OP_INSERT, 24'h000001, 16'h0001, 8'h00));
    send_request(make_req(OP_INSERT, 24'h800000, 16'h1234, 8'h00));
    send_request(make_req(OP_INSERT, 24'h000001, 16'hFFFF, 8'h00));
    for (int i = 0; i < 6; i++)
      send_request(make_req(OP_READ, 24'hFFFFFF, 16'hFFFF, SLOT_W'(i)));
    send_request(make_req(OP_READ,   '0,         '0,       8'd255));
    send_request(make_req(OP_UNUSED, '1,         '1,       '1));
    send_request(make_req(OP_UNUSED, '0,         '0,       '0));
    send_request(make_req(OP_CLEAR,  '1,         '1,       '1));
    send_request(make_req(OP_READ,   '0,         '0,       8'd0));
    send_request(make_req(OP_INSERT, 24'h000001, 16'h0000, 8'h00));
    send_request(make_req(OP_READ,   '0,         '0,       8'hAA));
    send_request(make_req(OP_READ,   '0,         '0,       8'h55));
    send_request(make_req(OP_CLEAR,  '0,         '0,       '0));
  endtask

  // fill past the end to saturate the count and push entries off the tail
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH + 40; i++)
      send_request(make_req(OP_INSERT, pick_score() | 24'd1, TAG_W'($urandom), SLOT_W'($urandom)));
    send_request(make_req(OP_READ,   '0,         '0,       8'd255));
    send_request(make_req(OP_READ,   '0,         '0,       8'd254));
    send_request(make_req(OP_INSERT, 24'h000001, 16'hBEEF, 8'd0));
    send_request(make_req(OP_INSERT, 24'hFFFFFF, 16'hCAFE, 8'd0));
    send_request(make_req(OP_READ,   '0,         '0,       8'd255));
  endtask

  task automatic test_backpressure();
    recv_hold = 200;
    for (int i = 0; i < 80; i++)
      send_request(make_req(i[0] ? OP_READ : OP_INSERT, pick_score(), TAG_W'($urandom),
                            SLOT_W'($urandom)));
    wait_for_results();
    for (int i = 0; i < 20; i++)
      send_request(make_req(OP_READ, pick_score(), TAG_W'($urandom), SLOT_W'(i)));
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned       roll;
    logic [1:0]        op;
    logic [SLOT_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(999);
      if (roll < 4)       op = OP_CLEAR;
      else if (roll < 24) op = OP_UNUSED;
      else if (roll < 640) op = OP_INSERT;
      else                op = OP_READ;
      if ($urandom_range(1) && shadow_filled > 0)
        idx = SLOT_W'($urandom_range(shadow_filled - 1));
      else
        idx = SLOT_W'($urandom);
      send_request(make_req(op, pick_score(), TAG_W'($urandom), idx));
    end
  endtask

  initial begin
    clear_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 74;
    test_directed();
    test_random(360);

    send_idle_pct = 74;
    recv_idle_pct = 23;
    test_random(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_list();
    test_backpressure();
    test_random(360);

    wait_for_results();
    repeat (8) @(posedge clk);

    $display("requests: %0d insert (%0d placed), %0d read, %0d clear, %0d unused opcode",
             op_counts[OP_INSERT], placed_count, op_counts[OP_READ], op_counts[OP_CLEAR],
             op_counts[OP_UNUSED]);
    $display("responses checked: %0d, deepest list: %0d entries, field errors: %0d",
             results_seen, peak_filled, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
